>>> design/vpfr_pkg.sv
// Package for the video payload frame reassembler.
// Holds widths, frame and packet limits, result types and queue sizing.
// No dependencies.
`timescale 1ns / 1ps

package vpfr_pkg;

  localparam int DATA_W           = 8;
  localparam int LEN_W            = 12;
  localparam int OFF_W            = 17;
  localparam int FRAME_BYTES      = 98304;
  localparam int MAX_PACKET_BYTES = 3072;
  localparam int MIN_VALID_LEN    = 2;
  localparam int EOF_BIT          = 1;

  // Write offset must hold FRAME_BYTES itself (frame full).
  localparam int WO_W    = $clog2(FRAME_BYTES + 1);
  // Packet length compares need room for MAX_PACKET_BYTES and position + 1.
  localparam int PLEN_W  = LEN_W + 1;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_FRAME   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               result_kind;
    logic [DATA_W-1:0]   payload_byte;
    logic [OFF_W-1:0]    frame_offset;
    logic                last_result;
  } result_t;

  // Up to two results per beat: slot a first, slot b is always a frame result.
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t a;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              room_for_two;
  } qstat_t;

endpackage

>>> design/vpfr_if.sv
// Valid/ready channel interfaces for the frame reassembler.
// Depends on vpfr_pkg for field widths.
`timescale 1ns / 1ps

interface vpfr_in_if import vpfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [LEN_W-1:0]  packet_length;
  logic              packet_ok;

  modport source (output valid, data_byte, packet_length, packet_ok, input ready);
  modport sink   (input valid, data_byte, packet_length, packet_ok, output ready);
endinterface

interface vpfr_out_if import vpfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [DATA_W-1:0] payload_byte;
  logic [OFF_W-1:0]  frame_offset;
  logic              last_result;

  modport source (output valid, result_kind, payload_byte, frame_offset, last_result,
                  input ready);
  modport sink   (input valid, result_kind, payload_byte, frame_offset, last_result,
                  output ready);
endinterface

>>> design/vpfr_parse.sv
// Input register, packet tracking state and per-beat result decode.
// Depends on vpfr_pkg and vpfr_in_if.
`timescale 1ns / 1ps

module vpfr_parse import vpfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  vpfr_in_if.sink      in_i,
  input  logic         room_i,
  output push_t        push_o
);

  logic              vld_q;
  logic [DATA_W-1:0] data_q;
  logic [LEN_W-1:0]  len_q;
  logic              ok_q;

  logic [LEN_W-1:0]  bpos_q, bpos_d;
  logic [DATA_W-1:0] hlen_q, hlen_d;
  logic              eof_q, eof_d;
  logic              acc_q, acc_d;
  logic [WO_W-1:0]   wo_q, wo_d;

  logic              fire;
  logic [PLEN_W-1:0] eff_len;
  logic              pkt_valid;
  logic              pos0;
  logic [DATA_W-1:0] hlen_cur;
  logic              acc_cur;
  logic              eof_cur;
  logic [WO_W:0]     fit_sum;
  logic              emit_byte;
  logic              emit_frame;
  logic [WO_W-1:0]   wo_mid;
  logic              last_beat;

  assign fire     = vld_q && room_i;
  assign in_i.ready = !vld_q || fire;

  always_comb begin
    if (PLEN_W'(len_q) > PLEN_W'(MAX_PACKET_BYTES)) begin
      eff_len = PLEN_W'(MAX_PACKET_BYTES);
    end else if (len_q == '0) begin
      eff_len = PLEN_W'(1);
    end else begin
      eff_len = PLEN_W'(len_q);
    end
  end

  assign pkt_valid = ok_q && (len_q >= LEN_W'(MIN_VALID_LEN));
  assign pos0      = (bpos_q == '0);
  assign hlen_cur  = pos0 ? data_q : hlen_q;
  // Whole payload must fit in what is left of the frame; decided on byte 0.
  assign fit_sum   = (WO_W + 1)'(wo_q) + (WO_W + 1)'(len_q - LEN_W'(data_q));

  always_comb begin
    if (pos0) begin
      acc_cur = pkt_valid && (LEN_W'(data_q) < len_q) &&
                (fit_sum <= (WO_W + 1)'(FRAME_BYTES));
      eof_cur = 1'b0;
    end else begin
      acc_cur = acc_q;
      eof_cur = (bpos_q == LEN_W'(1)) ? (pkt_valid && data_q[EOF_BIT]) : eof_q;
    end
  end

  assign emit_byte  = acc_cur && (bpos_q >= LEN_W'(hlen_cur)) &&
                      (wo_q < WO_W'(FRAME_BYTES));
  assign wo_mid     = wo_q + WO_W'(emit_byte);
  assign last_beat  = (PLEN_W'(bpos_q) + PLEN_W'(1)) >= eff_len;
  assign emit_frame = last_beat && eof_cur && (wo_mid >= WO_W'(FRAME_BYTES));

  always_comb begin
    if (last_beat) begin
      bpos_d = '0;
      hlen_d = '0;
      eof_d  = 1'b0;
      acc_d  = 1'b0;
      wo_d   = eof_cur ? '0 : wo_mid;
    end else begin
      bpos_d = bpos_q + LEN_W'(1);
      hlen_d = hlen_cur;
      eof_d  = eof_cur;
      acc_d  = acc_cur;
      wo_d   = wo_mid;
    end
  end

  always_comb begin
    push_o.push_a = fire && (emit_byte || emit_frame);
    push_o.push_b = fire && emit_byte && emit_frame;
    if (emit_byte) begin
      push_o.a.result_kind  = KIND_PAYLOAD;
      push_o.a.payload_byte = data_q;
      push_o.a.frame_offset = OFF_W'(wo_q);
      push_o.a.last_result  = !emit_frame;
    end else begin
      push_o.a.result_kind  = KIND_FRAME;
      push_o.a.payload_byte = '0;
      push_o.a.frame_offset = '0;
      push_o.a.last_result  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      bpos_q <= '0;
      hlen_q <= '0;
      eof_q  <= 1'b0;
      acc_q  <= 1'b0;
      wo_q   <= '0;
    end else begin
      if (in_i.ready) begin
        vld_q <= in_i.valid;
      end
      if (fire) begin
        bpos_q <= bpos_d;
        hlen_q <= hlen_d;
        eof_q  <= eof_d;
        acc_q  <= acc_d;
        wo_q   <= wo_d;
      end
    end
  end

  // Beat payload register.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q <= in_i.data_byte;
      len_q  <= in_i.packet_length;
      ok_q   <= in_i.packet_ok;
    end
  end

endmodule

>>> design/vpfr_outq.sv
// Small result queue: takes up to two results a cycle, drives one out.
// Depends on vpfr_pkg and vpfr_out_if.
`timescale 1ns / 1ps

module vpfr_outq import vpfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  push_t        push_i,
  vpfr_out_if.source   out_o,
  output qstat_t       stat_o
);

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;
  logic [QCNT_W-1:0] n_push;
  logic [QPTR_W-1:0] wr_next;
  result_t           frame_res;
  result_t           head;

  assign pop     = (cnt_q != '0) && out_o.ready;
  assign n_push  = QCNT_W'(push_i.push_a) + QCNT_W'(push_i.push_b);
  assign wr_next = wr_q + QPTR_W'(1);
  assign head    = mem_q[rd_q];

  always_comb begin
    frame_res.result_kind  = KIND_FRAME;
    frame_res.payload_byte = '0;
    frame_res.frame_offset = '0;
    frame_res.last_result  = 1'b1;
  end

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.result_kind  = head.result_kind;
  assign out_o.payload_byte = head.payload_byte;
  assign out_o.frame_offset = head.frame_offset;
  assign out_o.last_result  = head.last_result;

  assign stat_o.count        = cnt_q;
  assign stat_o.room_for_two = (cnt_q <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_W'(n_push);
      cnt_q <= cnt_q + n_push - QCNT_W'(pop);
      if (pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_q] <= push_i.a;
    end
    if (push_i.push_b) begin
      mem_q[wr_next] <= frame_res;
    end
  end

endmodule

>>> design/video_payload_frame_reassembler_unit.sv
// Channel   Dir  Beat contents
// in_i      in   data_byte, packet_length, packet_ok
// out_o     out  result_kind, payload_byte, frame_offset, last_result
//
// One input beat per cycle sustained while the result queue has room for two;
// an accepted beat goes through the input register, then the result queue.
// Throughput is set by the four-entry result queue: a registered beat is
// processed only while two slots are free. Reset clears packet position
// and frame offset.
// Output stalls back up through the queue to in_i.ready.
// Top level; depends on vpfr_pkg, vpfr_if, vpfr_parse and vpfr_outq.
`timescale 1ns / 1ps

module video_payload_frame_reassembler_unit import vpfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vpfr_in_if.sink     in_i,
  vpfr_out_if.source  out_o
);

  push_t  push;
  qstat_t qstat;

  vpfr_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (qstat.room_for_two),
    .push_o (push)
  );

  vpfr_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .out_o  (out_o),
    .stat_o (qstat)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push_b |-> (push.push_a && push.a.result_kind == KIND_PAYLOAD &&
                     !push.a.last_result))
    else $error("second result without a leading payload byte");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.push_a && !push.push_b) |-> push.a.last_result)
    else $error("single result not marked last");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push_a |-> $past(qstat.room_for_two) || qstat.room_for_two ||
                    qstat.count <= QCNT_W'(QDEPTH - 2))
    else $error("push without queue room");
`endif

endmodule

>>> verif/tb.sv
// Testbench for video_payload_frame_reassembler_unit: byte-wise packet stimulus, a
// self-checking reassembly predictor and an in-order result scoreboard.
// Depends on vpfr_pkg, vpfr_if and the reassembler RTL.
`timescale 1ns / 1ps

module tb;
  import vpfr_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int RANDOM_BEATS = 1600;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              packet_ok;
  } beat_t;

  logic clk;
  logic rst_n;

  vpfr_in_if  in_if ();
  vpfr_out_if out_if ();

  video_payload_frame_reassembler_unit i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Reassembly state, mirrors the block from reset
  logic [LEN_W-1:0]  pkt_pos  = '0;
  logic [DATA_W-1:0] pkt_hdr  = '0;
  logic              pkt_eof  = 1'b0;
  logic              pkt_take = 1'b0;
  int unsigned       frame_wr = 0;

  result_t     pending_results [$];
  result_t     want_r;
  int unsigned mismatch_cnt = 0;
  int unsigned useful_beats = 0;
  int unsigned cycle_cnt    = 0;
  int          src_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        rx_hold;
  event        hold_start;

  always #5 clk = ~clk;

  function automatic int unsigned pkt_span(int unsigned plen);
    if (plen > MAX_PACKET_BYTES) return MAX_PACKET_BYTES;
    if (plen < 1) return 1;
    return plen;
  endfunction

  // Advance the packet/frame state by one beat and queue the results it causes.
  function automatic void reassemble_step(beat_t b);
    result_t     res [2];
    int          n;
    int unsigned span;
    bit          pkt_valid;
    n = 0;
    span = pkt_span(b.packet_length);
    pkt_valid = b.packet_ok && (b.packet_length >= MIN_VALID_LEN);
    if (pkt_pos == 0) begin
      pkt_hdr  = b.data_byte;
      pkt_eof  = 1'b0;
      pkt_take = 1'b0;
      if (pkt_valid && int'(pkt_hdr) < int'(b.packet_length) &&
          frame_wr + (int'(b.packet_length) - int'(pkt_hdr)) <= FRAME_BYTES)
        pkt_take = 1'b1;
    end else if (pkt_pos == 1) begin
      pkt_eof = pkt_valid && b.data_byte[EOF_BIT];
    end
    if (pkt_take && int'(pkt_pos) >= int'(pkt_hdr) && frame_wr < FRAME_BYTES) begin
      res[n].result_kind  = KIND_PAYLOAD;
      res[n].payload_byte = b.data_byte;
      res[n].frame_offset = frame_wr[OFF_W-1:0];
      res[n].last_result  = 1'b0;
      n++;
      frame_wr++;
    end
    if (int'(pkt_pos) + 1 >= span) begin
      if (pkt_eof) begin
        if (frame_wr >= FRAME_BYTES) begin
          res[n].result_kind  = KIND_FRAME;
          res[n].payload_byte = '0;
          res[n].frame_offset = '0;
          res[n].last_result  = 1'b0;
          n++;
        end
        frame_wr = 0;
      end
      pkt_pos  = '0;
      pkt_hdr  = '0;
      pkt_eof  = 1'b0;
      pkt_take = 1'b0;
    end else begin
      pkt_pos = pkt_pos + 1'b1;
    end
    if (n > 0) res[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid         <= 1'b0;
      in_if.data_byte     <= DATA_W'($urandom_range(255));
      in_if.packet_length <= LEN_W'($urandom_range(4095));
      in_if.packet_ok     <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b.data_byte;
    in_if.packet_length <= b.packet_length;
    in_if.packet_ok     <= b.packet_ok;
    do @(posedge clk); while (!in_if.ready);
    reassemble_step(b);
    @(negedge clk);
  endtask

  task automatic send_packet(input int unsigned plen, input bit ok, input logic [7:0] hdr,
                             input logic [7:0] flags, input int unsigned nbytes);
    beat_t b;
    for (int i = 0; i < nbytes; i++) begin
      b.data_byte     = (i == 0) ? hdr : (i == 1) ? flags : 8'($urandom_range(255));
      b.packet_length = plen[LEN_W-1:0];
      b.packet_ok     = ok;
      send_beat(b);
      if (ok && plen >= MIN_VALID_LEN) useful_beats++;
    end
  endtask

  task automatic send_noise_beat();
    beat_t b;
    b.data_byte     = DATA_W'($urandom_range(255));
    b.packet_length = LEN_W'($urandom_range(4095));
    b.packet_ok     = 1'($urandom_range(1));
    send_beat(b);
  endtask

  // Close any open packet with a one-byte length.
  task automatic realign();
    beat_t b;
    if (pkt_pos != 0) begin
      b.data_byte     = DATA_W'($urandom_range(255));
      b.packet_length = LEN_W'(1);
      b.packet_ok     = 1'($urandom_range(1));
      send_beat(b);
    end
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin src_idle_pct = 53; rx_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  rx_stall_pct = 53; end
      default: begin src_idle_pct = 23; rx_stall_pct = 23; end
    endcase
  endtask

  task automatic send_random_packet();
    int unsigned plen;
    int unsigned hdr;
    int unsigned pick;
    bit          ok;
    logic [7:0]  flags;
    plen = ($urandom_range(9) == 0) ? $urandom_range(25, 400) : $urandom_range(2, 24);
    pick = $urandom_range(9);
    if (pick < 3) hdr = $urandom_range(1);
    else if (pick < 9) hdr = $urandom_range(2, plen);
    else hdr = $urandom_range(255);
    if (hdr > 255) hdr = 255;
    ok    = ($urandom_range(9) != 0);
    flags = 8'($urandom_range(255));
    send_packet(plen, ok, hdr[7:0], flags, pkt_span(plen));
  endtask

  // Cut a packet short, stir in noise, then close it.
  task automatic send_broken_packet();
    int unsigned plen;
    int unsigned cut;
    plen = $urandom_range(3, 24);
    cut  = $urandom_range(1, plen - 1);
    send_packet(plen, 1'b1, 8'($urandom_range(3)), 8'($urandom_range(255)), cut);
    repeat ($urandom_range(3)) send_noise_beat();
    realign();
  endtask

  task automatic test_directed();
    beat_t b;
    set_idling(0);
    send_packet(0, 1'b1, 8'hFF, 8'h00, 1);  // zero length: one-byte packet, dropped
    send_packet(1, 1'b1, 8'h00, 8'h00, 1);
    send_packet(4, 1'b0, 8'h00, 8'h02, 4);  // failed status
    send_packet(2, 1'b1, 8'h00, 8'h02, 2);  // header bytes are payload, end of frame
    send_packet(3, 1'b1, 8'h01, 8'hFD, 3);
    send_packet(3, 1'b1, 8'h03, 8'h02, 3);  // header fills packet: empty payload
    send_packet(4, 1'b1, 8'hFF, 8'hFF, 4);  // header past packet end
    // status drops after byte 0: payload kept, end-of-frame flag lost
    b = '{8'h02, 12'd4, 1'b1}; send_beat(b);
    b = '{8'h02, 12'd4, 1'b0}; send_beat(b);
    b = '{8'hFF, 12'd4, 1'b0}; send_beat(b);
    b = '{8'h00, 12'd4, 1'b0}; send_beat(b);
    // length shrinks mid-packet and ends it early
    send_packet(6, 1'b1, 8'h02, 8'h02, 3);
    b = '{8'h55, 12'd3, 1'b1}; send_beat(b);
  endtask

  task automatic test_backpressure();
    set_idling(0);
    realign();
    -> hold_start;
    repeat (8) send_packet(10, 1'b1, 8'h02, 8'($urandom_range(255)), 10);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned sel;
    for (int ph = 0; ph < 4; ph++) begin
      set_idling(ph);
      goal = useful_beats + RANDOM_BEATS / 4;
      while (useful_beats < goal) begin
        realign();
        sel = $urandom_range(9);
        if (sel < 8) send_random_packet();
        else if (sel == 8) send_broken_packet();
        else repeat ($urandom_range(1, 4)) send_noise_beat();
      end
    end
  endtask

  // Long receiver hold-off, counted here
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_start);
      rx_hold = 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
      rx_hold = 1'b0;
    end
  end

  always @(negedge clk) begin
    out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: kind %0d byte %02h offset %0d last %0b",
                   out_if.result_kind, out_if.payload_byte, out_if.frame_offset,
                   out_if.last_result);
      end else begin
        want_r = pending_results.pop_front();
        if (out_if.result_kind !== want_r.result_kind ||
            out_if.payload_byte !== want_r.payload_byte ||
            out_if.frame_offset !== want_r.frame_offset ||
            out_if.last_result !== want_r.last_result) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("result mismatch: expected kind %0d byte %02h offset %0d last %0b,",
                     want_r.result_kind, want_r.payload_byte, want_r.frame_offset,
                     want_r.last_result);
            $display("  got kind %0d byte %02h offset %0d last %0b",
                     out_if.result_kind, out_if.payload_byte,
                     out_if.frame_offset, out_if.last_result);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.packet_length = '0;
    in_if.packet_ok     = 1'b0;
    out_if.ready        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random_traffic();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

>>> video_payload_frame_reassembler_unit.f
design/vpfr_pkg.sv
design/vpfr_if.sv
design/vpfr_parse.sv
design/vpfr_outq.sv
design/video_payload_frame_reassembler_unit.sv
verif/tb.sv
